// ===== rtl/core/sst_pkg.sv =====
// Shared types, constants and helper functions of the source tokeniser.
package sst_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_FRACTION_DIGITS_DEF = 9;

    // Scanner modes.
    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_COMMENT = 4'd1,
        M_NUMBER  = 4'd2,
        M_NUMDOT  = 4'd3,
        M_FRAC    = 4'd4,
        M_NAME    = 4'd5,
        M_TEXT    = 4'd6,
        M_MINUS   = 4'd7,
        M_BAR     = 4'd8,
        M_EQUAL   = 4'd9,
        M_BANG    = 4'd10,
        M_LESS    = 4'd11,
        M_GREATER = 4'd12
    } mode_t;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_ERROR   = 6'd1;
    localparam logic [5:0] K_INT     = 6'd2;
    localparam logic [5:0] K_REAL    = 6'd3;
    localparam logic [5:0] K_TEXT    = 6'd4;
    localparam logic [5:0] K_NAME    = 6'd5;
    localparam logic [5:0] K_PLUS    = 6'd33;
    localparam logic [5:0] K_MINUS   = 6'd34;
    localparam logic [5:0] K_STAR    = 6'd35;
    localparam logic [5:0] K_SLASH   = 6'd36;
    localparam logic [5:0] K_PCT     = 6'd37;
    localparam logic [5:0] K_CARET   = 6'd38;
    localparam logic [5:0] K_EQEQ    = 6'd39;
    localparam logic [5:0] K_NE      = 6'd40;
    localparam logic [5:0] K_LT      = 6'd41;
    localparam logic [5:0] K_LE      = 6'd42;
    localparam logic [5:0] K_GT      = 6'd43;
    localparam logic [5:0] K_GE      = 6'd44;
    localparam logic [5:0] K_ASSIGN  = 6'd45;
    localparam logic [5:0] K_LPAR    = 6'd46;
    localparam logic [5:0] K_RPAR    = 6'd47;
    localparam logic [5:0] K_LBRK    = 6'd48;
    localparam logic [5:0] K_RBRK    = 6'd49;
    localparam logic [5:0] K_LBRC    = 6'd50;
    localparam logic [5:0] K_RBRC    = 6'd51;
    localparam logic [5:0] K_COMMA   = 6'd52;
    localparam logic [5:0] K_COLON   = 6'd53;
    localparam logic [5:0] K_DOT     = 6'd54;
    localparam logic [5:0] K_ARROW   = 6'd55;
    localparam logic [5:0] K_PIPE    = 6'd56;
    localparam logic [5:0] K_NEWLINE = 6'd57;

    localparam int NUM_KW = 29;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic [31:0] line;
        logic [63:0] ival;
        logic [63:0] rval;
    } token_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic busy;       // token queue or divider still working
    } dp_status_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic take;       // run one scanner step on the input transfer
    } dp_cmd_t;

    // Keyword packing: bytes little-endian in 56 bits, plus length.
    function automatic logic [55:0] kw_packed(input int i);
        logic [55:0] p;
        p = '0;
        case (i)
            0:  p = 56'h74656c;
            1:  p = 56'h796173;
            2:  p = 56'h6b7361;
            3:  p = 56'h6669;
            4:  p = 56'h6e656874;
            5:  p = 56'h65736c65;
            6:  p = 56'h646e65;
            7:  p = 56'h656c696877;
            8:  p = 56'h7461657065_72;
            9:  p = 56'h6c69746e75;
            10: p = 56'h726f66;
            11: p = 56'h68636165;
            12: p = 56'h6e69;
            13: p = 56'h6e7566;
            14: p = 56'h6e72757465_72;
            15: p = 56'h6b61657262;
            16: p = 56'h70696b73;
            17: p = 56'h686374616d;
            18: p = 56'h6e656877;
            19: p = 56'h646e61;
            20: p = 56'h726f;
            21: p = 56'h746f6e;
            22: p = 56'h7369;
            23: p = 56'h65757274;
            24: p = 56'h736579;
            25: p = 56'h65736c6166;
            26: p = 56'h6f6e;
            27: p = 56'h676e696874_6f6e;
            default: p = 56'h6f74;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] kw_len(input int i);
        logic [2:0] n;
        case (i)
            3, 12, 20, 22, 26, 28: n = 3'd2;
            4, 5, 11, 16, 18, 23: n = 3'd4;
            7, 9, 15, 17, 25: n = 3'd5;
            8, 14: n = 3'd6;
            27: n = 3'd7;
            default: n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] kw_kind(input int i);
        logic [5:0] k;
        if (i <= 23) k = 6'(i + 6);
        else if (i == 24) k = 6'd29;
        else if (i <= 26) k = 6'd30;
        else k = 6'(i + 4);
        return k;
    endfunction

    function automatic logic numeral_char(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f);
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {15'd0, b};
        return s[16] ? 16'hffff : s[15:0];
    endfunction

    function automatic logic [63:0] pow10(input logic [3:0] k);
        logic [63:0] p;
        case (k)
            4'd0: p = 64'd1;
            4'd1: p = 64'd10;
            4'd2: p = 64'd100;
            4'd3: p = 64'd1000;
            4'd4: p = 64'd10000;
            4'd5: p = 64'd100000;
            4'd6: p = 64'd1000000;
            4'd7: p = 64'd10000000;
            4'd8: p = 64'd100000000;
            default: p = 64'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/sst_if.sv =====
// Valid/ready channel interfaces for bytes in and tokens out.
interface sst_byte_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;
    modport source (output valid, kind, byte_value, input ready);
    modport sink (input valid, kind, byte_value, output ready);
endinterface

interface sst_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [31:0] token_line;
    logic [63:0] integer_value;
    logic [63:0] real_value;
    logic        last_of_run;
    modport source (output valid, token_kind, token_start, token_length, token_line,
                    integer_value, real_value, last_of_run, input ready);
    modport sink (input valid, token_kind, token_start, token_length, token_line,
                  integer_value, real_value, last_of_run, output ready);
endinterface

// ===== rtl/core/sst_ctrl.sv =====
// Controller: accepts a byte when the datapath has drained its previous step.
module sst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sst_pkg::dp_status_t status,
    output sst_pkg::dp_cmd_t    cmd
);
    typedef enum logic [1:0] {
        S_READY = 2'b01,
        S_WAIT  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_READY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        case (state_reg)
            S_READY:
            begin
                in_ready = !status.busy;
                if (in_valid && !status.busy)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // wait here so the step's tokens reach the queue
                state_next = S_READY;
            end
            default: state_next = S_READY;
        endcase
        cmd.take = in_valid && in_ready;
    end
endmodule

// ===== rtl/core/sst_div.sv =====
// Restoring divider for the fraction part: one quotient bit a cycle.
module sst_div #(
    parameter int FRAC_BITS = sst_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [29:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);
    localparam int NB = 30 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] num_reg;
    logic [30:0]   rem_reg;
    logic [29:0]   den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [30:0]   trial;
    logic [31:0]   diff;

    assign trial = {rem_reg[29:0], num_reg[NB-1]};
    assign diff = {1'b0, trial} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[NB-1:0];
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NB-2:0], !diff[31]};
            rem_reg <= diff[31] ? trial : diff[30:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = 64'(num_reg);
endmodule

// ===== rtl/core/sst_dp.sv =====
// Datapath: scanner state, token builder, three-entry token queue and divider.
module sst_dp #(
    parameter int FRAC_BITS = sst_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRACTION_DIGITS = sst_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sst_pkg::dp_cmd_t    cmd,
    input  logic                in_kind,
    input  logic [7:0]          in_byte,
    output sst_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_ready,
    output sst_pkg::token_t     out_tok,
    output logic                out_last
);
    sst_pkg::mode_t mode_reg, mode_next;
    logic [31:0] line_reg, line_next;
    logic [31:0] offs_reg, offs_next;
    logic [31:0] pstart_reg, pstart_next;
    logic [15:0] plen_reg, plen_next;
    logic [31:0] pline_reg, pline_next;
    logic [63:0] whole_reg, whole_next;
    logic [29:0] fnum_reg, fnum_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [55:0] prefix_reg, prefix_next;
    logic        esc_reg, esc_next;

    // Up to three tokens per step; slot 0 may be a real awaiting division.
    sst_pkg::token_t q_reg [3];
    sst_pkg::token_t q_next [3];
    logic [1:0] qn_reg, qn_next, qh_reg;
    logic       wait_div_reg;

    sst_pkg::token_t t [3];
    logic [1:0] nt;
    logic need_div;
    logic [63:0] div_q;
    logic div_busy, div_done;
    logic [5:0] kw_hit;
    logic [63:0] ten_whole;
    logic [29:0] ten_frac;

    sst_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.take && need_div),
        .dividend({34'd0, fnum_reg} << FRAC_BITS),
        .divisor(30'(sst_pkg::pow10(fcnt_reg))),
        .busy(div_busy), .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        kw_hit = sst_pkg::K_NAME;
        for (int i = sst_pkg::NUM_KW - 1; i >= 0; i--)
        begin
            if (plen_reg == {13'd0, sst_pkg::kw_len(i)} && prefix_reg == sst_pkg::kw_packed(i))
            begin
                kw_hit = sst_pkg::kw_kind(i);
            end
        end
    end

    assign ten_whole = (whole_reg << 3) + (whole_reg << 1);
    assign ten_frac = (fnum_reg << 3) + (fnum_reg << 1);

    // One scanner step as in the behaviour: flush, then start byte.
    always_comb
    begin
        logic [7:0] c;
        logic eoi, do_flush, do_start;
        logic [5:0] sk, pk;
        logic [7:0] second;
        sst_pkg::token_t tk;
        c = in_byte;
        eoi = in_kind || (in_byte == 8'd0);
        do_flush = 1'b0;
        do_start = 1'b0;
        need_div = 1'b0;
        nt = 2'd0;
        for (int i = 0; i < 3; i++) t[i] = '0;
        mode_next = mode_reg;
        line_next = line_reg;
        offs_next = offs_reg + 32'd1;
        pstart_next = pstart_reg;
        plen_next = plen_reg;
        pline_next = pline_reg;
        whole_next = whole_reg;
        fnum_next = fnum_reg;
        fcnt_next = fcnt_reg;
        prefix_next = prefix_reg;
        esc_next = esc_reg;
        sk = sst_pkg::K_GT;
        second = 8'h3d;
        pk = sst_pkg::K_GE;
        case (mode_reg)
            sst_pkg::M_MINUS:   begin sk = sst_pkg::K_MINUS; second = 8'h3e; pk = sst_pkg::K_ARROW; end
            sst_pkg::M_BAR:     begin sk = sst_pkg::K_ERROR; second = 8'h3e; pk = sst_pkg::K_PIPE; end
            sst_pkg::M_EQUAL:   begin sk = sst_pkg::K_ASSIGN; pk = sst_pkg::K_EQEQ; end
            sst_pkg::M_BANG:    begin sk = sst_pkg::K_ERROR; pk = sst_pkg::K_NE; end
            sst_pkg::M_LESS:    begin sk = sst_pkg::K_LT; pk = sst_pkg::K_LE; end
            default: ;
        endcase
        tk = '0;
        tk.start = pstart_reg;
        tk.length = plen_reg;
        tk.line = pline_reg;
        if (eoi)
        begin
            do_flush = 1'b1;
        end
        else
        begin
            case (mode_reg)
                sst_pkg::M_IDLE: do_start = 1'b1;
                sst_pkg::M_COMMENT: do_start = (c == 8'h0a);
                sst_pkg::M_NUMBER:
                begin
                    if (sst_pkg::numeral_char(c))
                    begin
                        whole_next = ten_whole + {60'd0, c[3:0]};
                        plen_next = sst_pkg::sat_add(plen_reg, 2'd1);
                    end
                    else if (c == 8'h2e) mode_next = sst_pkg::M_NUMDOT;
                    else begin do_flush = 1'b1; do_start = 1'b1; end
                end
                sst_pkg::M_NUMDOT:
                begin
                    if (sst_pkg::numeral_char(c))
                    begin
                        mode_next = sst_pkg::M_FRAC;
                        plen_next = sst_pkg::sat_add(plen_reg, 2'd2);
                        fnum_next = {26'd0, c[3:0]};
                        fcnt_next = 4'd1;
                    end
                    else begin do_flush = 1'b1; do_start = 1'b1; end
                end
                sst_pkg::M_FRAC:
                begin
                    if (sst_pkg::numeral_char(c) && fcnt_reg < 4'(MAX_FRACTION_DIGITS))
                    begin
                        fnum_next = ten_frac + {26'd0, c[3:0]};
                        fcnt_next = fcnt_reg + 4'd1;
                        plen_next = sst_pkg::sat_add(plen_reg, 2'd1);
                    end
                    else begin do_flush = 1'b1; do_start = 1'b1; end
                end
                sst_pkg::M_NAME:
                begin
                    if (sst_pkg::letter_char(c) || sst_pkg::numeral_char(c))
                    begin
                        for (int b = 0; b < 7; b++)
                        begin
                            if (plen_reg == 16'(b)) prefix_next[8*b +: 8] = c;
                        end
                        plen_next = sst_pkg::sat_add(plen_reg, 2'd1);
                    end
                    else begin do_flush = 1'b1; do_start = 1'b1; end
                end
                sst_pkg::M_TEXT:
                begin
                    if (!esc_reg && c == 8'h22)
                    begin
                        tk.kind = sst_pkg::K_TEXT;
                        t[0] = tk;
                        nt = 2'd1;
                        mode_next = sst_pkg::M_IDLE;
                    end
                    else
                    begin
                        esc_next = esc_reg ? 1'b0 : (c == 8'h5c);
                        if (c == 8'h0a) line_next = line_reg + 32'd1;
                        plen_next = sst_pkg::sat_add(plen_reg, 2'd1);
                    end
                end
                default:
                begin
                    if (c == second)
                    begin
                        tk.kind = pk;
                        tk.length = 16'd2;
                        t[0] = tk;
                        nt = 2'd1;
                        mode_next = sst_pkg::M_IDLE;
                    end
                    else begin do_flush = 1'b1; do_start = 1'b1; end
                end
            endcase
        end
        if (do_flush)
        begin
            mode_next = sst_pkg::M_IDLE;
            case (mode_reg)
                sst_pkg::M_NUMBER:
                begin
                    tk.kind = sst_pkg::K_INT; tk.ival = whole_reg; t[0] = tk; nt = 2'd1;
                end
                sst_pkg::M_NUMDOT:
                begin
                    tk.kind = sst_pkg::K_INT; tk.ival = whole_reg; t[0] = tk;
                    t[1] = '0;
                    t[1].kind = sst_pkg::K_DOT;
                    t[1].start = offs_reg - 32'd1;
                    t[1].length = 16'd1;
                    t[1].line = pline_reg;
                    nt = 2'd2;
                end
                sst_pkg::M_FRAC:
                begin
                    tk.kind = sst_pkg::K_REAL;
                    tk.rval = whole_reg << FRAC_BITS;
                    t[0] = tk; nt = 2'd1; need_div = 1'b1;
                end
                sst_pkg::M_NAME:
                begin
                    tk.kind = (plen_reg <= 16'd7) ? kw_hit : sst_pkg::K_NAME;
                    t[0] = tk; nt = 2'd1;
                end
                sst_pkg::M_TEXT:
                begin
                    tk.kind = sst_pkg::K_TEXT; t[0] = tk; nt = 2'd1;
                end
                sst_pkg::M_MINUS, sst_pkg::M_BAR, sst_pkg::M_EQUAL, sst_pkg::M_BANG,
                sst_pkg::M_LESS, sst_pkg::M_GREATER:
                begin
                    tk.kind = sk; tk.length = 16'd1; t[0] = tk; nt = 2'd1;
                end
                default: ;
            endcase
        end
        if (eoi)
        begin
            t[nt] = '0;
            t[nt].kind = sst_pkg::K_EOF;
            t[nt].start = offs_reg;
            t[nt].line = line_reg;
            nt = nt + 2'd1;
            mode_next = sst_pkg::M_IDLE;
            line_next = 32'd1;
            offs_next = '0;
            pstart_next = '0;
            plen_next = '0;
            pline_next = 32'd1;
            whole_next = '0;
            fnum_next = '0;
            fcnt_next = '0;
            prefix_next = '0;
            esc_next = 1'b0;
        end
        else if (do_start)
        begin
            mode_next = sst_pkg::M_IDLE;
            tk = '0;
            tk.start = offs_reg;
            tk.length = 16'd1;
            tk.line = line_reg;
            if (c == 8'h20 || c == 8'h09 || c == 8'h0d)
            begin
            end
            else if (c == 8'h23) mode_next = sst_pkg::M_COMMENT;
            else if (c == 8'h0a)
            begin
                tk.kind = sst_pkg::K_NEWLINE;
                t[nt] = tk;
                nt = nt + 2'd1;
                line_next = line_reg + 32'd1;
            end
            else if (sst_pkg::numeral_char(c) || sst_pkg::letter_char(c) || c == 8'h22
                     || c == 8'h2d || c == 8'h7c || c == 8'h3d || c == 8'h21
                     || c == 8'h3c || c == 8'h3e)
            begin
                pstart_next = offs_reg;
                plen_next = 16'd1;
                pline_next = line_reg;
                if (sst_pkg::numeral_char(c))
                begin
                    mode_next = sst_pkg::M_NUMBER;
                    whole_next = {60'd0, c[3:0]};
                end
                else if (sst_pkg::letter_char(c))
                begin
                    mode_next = sst_pkg::M_NAME;
                    prefix_next = {48'd0, c};
                end
                else
                begin
                    case (c)
                        8'h22:
                        begin
                            mode_next = sst_pkg::M_TEXT;
                            pstart_next = offs_reg + 32'd1;
                            plen_next = 16'd0;
                            esc_next = 1'b0;
                        end
                        8'h2d: mode_next = sst_pkg::M_MINUS;
                        8'h7c: mode_next = sst_pkg::M_BAR;
                        8'h3d: mode_next = sst_pkg::M_EQUAL;
                        8'h21: mode_next = sst_pkg::M_BANG;
                        8'h3c: mode_next = sst_pkg::M_LESS;
                        default: mode_next = sst_pkg::M_GREATER;
                    endcase
                end
            end
            else
            begin
                case (c)
                    8'h2b: tk.kind = sst_pkg::K_PLUS;
                    8'h2a: tk.kind = sst_pkg::K_STAR;
                    8'h2f: tk.kind = sst_pkg::K_SLASH;
                    8'h25: tk.kind = sst_pkg::K_PCT;
                    8'h5e: tk.kind = sst_pkg::K_CARET;
                    8'h28: tk.kind = sst_pkg::K_LPAR;
                    8'h29: tk.kind = sst_pkg::K_RPAR;
                    8'h5b: tk.kind = sst_pkg::K_LBRK;
                    8'h5d: tk.kind = sst_pkg::K_RBRK;
                    8'h7b: tk.kind = sst_pkg::K_LBRC;
                    8'h7d: tk.kind = sst_pkg::K_RBRC;
                    8'h2c: tk.kind = sst_pkg::K_COMMA;
                    8'h3a: tk.kind = sst_pkg::K_COLON;
                    8'h2e: tk.kind = sst_pkg::K_DOT;
                    default: tk.kind = sst_pkg::K_ERROR;
                endcase
                t[nt] = tk;
                nt = nt + 2'd1;
            end
        end
    end

    // Queue: fill on a step, drain one transfer at a time from the head.
    always_comb
    begin
        for (int i = 0; i < 3; i++) q_next[i] = q_reg[i];
        qn_next = qn_reg;
        if (cmd.take)
        begin
            for (int i = 0; i < 3; i++) q_next[i] = t[i];
            qn_next = nt;
        end
        else if (div_done)
        begin
            q_next[0].rval = q_reg[0].rval + div_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sst_pkg::M_IDLE;
            line_reg <= 32'd1;
            offs_reg <= '0;
            pstart_reg <= '0;
            plen_reg <= '0;
            pline_reg <= 32'd1;
            whole_reg <= '0;
            fnum_reg <= '0;
            fcnt_reg <= '0;
            prefix_reg <= '0;
            esc_reg <= 1'b0;
            qn_reg <= '0;
            qh_reg <= '0;
            wait_div_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                mode_reg <= mode_next;
                line_reg <= line_next;
                offs_reg <= offs_next;
                pstart_reg <= pstart_next;
                plen_reg <= plen_next;
                pline_reg <= pline_next;
                whole_reg <= whole_next;
                fnum_reg <= fnum_next;
                fcnt_reg <= fcnt_next;
                prefix_reg <= prefix_next;
                esc_reg <= esc_next;
                qn_reg <= qn_next;
                qh_reg <= '0;
                wait_div_reg <= need_div;
            end
            else
            begin
                if (div_done) wait_div_reg <= 1'b0;
                if (out_valid && out_ready) qh_reg <= qh_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) q_reg[i] <= q_next[i];
    end

    assign out_valid = (qh_reg < qn_reg) && !wait_div_reg && !div_busy;
    assign out_tok = q_reg[qh_reg];
    assign out_last = (qh_reg + 2'd1 == qn_reg);
    assign status.busy = (qh_reg < qn_reg) || wait_div_reg || div_busy;
endmodule

// ===== rtl/core/script_source_tokenizer.sv =====
// Top level of the source tokeniser: byte channel in, token channel out.
//
//  channel | role | payload                                     | transfer when
//  --------+------+---------------------------------------------+-----------------
//  src     | sink | kind, byte_value                            | valid && ready
//  tok     | src  | token_kind/start/length/line, values, last  | valid && ready
//
// A byte is taken and its tokens (0 to 3 transfers) are written to the token queue
// and offered from there; ready rises again once the last of them has gone, so no
// new byte is taken while tokens of the previous one are pending. A real number
// ending runs the fraction division in the shift-subtract divider, which holds the
// tokens back until its quotient is added. The token queue holds its head while
// the sink stalls. Reset is asynchronous and returns the scanner to line 1,
// offset 0, between tokens.
module script_source_tokenizer #(
    parameter int FRAC_BITS = sst_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRACTION_DIGITS = sst_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    sst_byte_if.sink      src,
    sst_token_if.source   tok
);
    sst_pkg::dp_status_t status;
    sst_pkg::dp_cmd_t    cmd;
    sst_pkg::token_t     head;

    // Controller: paces transfers on the byte side.
    sst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(src.valid), .in_ready(src.ready),
        .status(status), .cmd(cmd)
    );

    // Datapath: scanner, keyword match, divider and token queue.
    sst_dp #(
        .FRAC_BITS(FRAC_BITS), .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_kind(src.kind), .in_byte(src.byte_value),
        .status(status),
        .out_valid(tok.valid), .out_ready(tok.ready),
        .out_tok(head), .out_last(tok.last_of_run)
    );

    assign tok.token_kind = head.kind;
    assign tok.token_start = head.start;
    assign tok.token_length = head.length;
    assign tok.token_line = head.line;
    assign tok.integer_value = head.ival;
    assign tok.real_value = head.rval;
endmodule

// ===== rtl/core/sst_checker.sv =====
// Port-level checks for the tokeniser, bound to the top level.
module sst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_last,
    input logic [5:0] out_kind
);
    // No new byte while tokens still wait.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("byte taken while tokens pending");
    // Ready drops straight after a byte transfer.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready held after transfer");
    // End of file is always the last token of its run.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == sst_pkg::K_EOF) |-> out_last)
        else $error("eof not last");
    // A stalled token holds its kind.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_kind)))
        else $error("token dropped");
endmodule

bind script_source_tokenizer sst_checker u_sst_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(src.valid), .in_ready(src.ready),
    .out_valid(tok.valid), .out_ready(tok.ready),
    .out_last(tok.last_of_run), .out_kind(tok.token_kind)
);

// ===== tb/script_source_tokenizer_checker.sv =====
// Token checker: watches both channels, predicts the token stream and compares it.
`timescale 1ns / 1ps
module script_source_tokenizer_checker (
    input  logic  clk,
    input  logic  rst_n,
    sst_byte_if   src_mon,
    sst_token_if  tok_mon,
    output int    fails,
    output int    pending,
    output int    bytes_seen,
    output int    tokens_seen
);

    localparam int FRAC = sst_pkg::FRAC_BITS_DEF;
    localparam int MAX_DIGITS = sst_pkg::MAX_FRACTION_DIGITS_DEF;
    localparam logic [7:0] CH_LF = 8'h0a;

    typedef struct {
        sst_pkg::token_t tok;
        bit              last;
    } expected_token_t;

    expected_token_t token_fifo[$];

    string    kw_words[29] = '{"let", "say", "ask", "if", "then", "else", "end",
        "while", "repeat", "until", "for", "each", "in", "fun", "return", "break",
        "skip", "match", "when", "and", "or", "not", "is", "true", "yes", "false",
        "no", "nothing", "to"};
    int       kw_kinds[29] = '{6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19,
        20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 29, 30, 30, 31, 32};

    sst_pkg::mode_t mode;
    bit [31:0]   line_no, offset, tok_start, tok_line;
    bit [15:0]   tok_len;
    bit [63:0]   whole;
    bit [29:0]   frac_num;
    int          frac_digits;
    string       name_buf;
    bit          esc;

    function automatic void clear_scanner();
        mode = sst_pkg::M_IDLE;
        line_no = 1;
        offset = 0;
        tok_start = 0;
        tok_len = 0;
        tok_line = 1;
        whole = 0;
        frac_num = 0;
        frac_digits = 0;
        name_buf = "";
        esc = 0;
    endfunction

    function automatic void push(bit [5:0] k, bit [31:0] s, bit [15:0] l, bit [31:0] ln,
                                 bit [63:0] iv, bit [63:0] rv);
        expected_token_t e;
        e.tok = '{kind: k, start: s, length: l, line: ln, ival: iv, rval: rv};
        e.last = 0;
        token_fifo.push_back(e);
    endfunction

    function automatic bit [15:0] len_plus(bit [15:0] a, int b);
        return (int'(a) + b > 65535) ? 16'hffff : 16'(int'(a) + b);
    endfunction

    function automatic bit digit_char(bit [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit name_char(bit [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void op_kinds(sst_pkg::mode_t m, output bit [5:0] single,
                                     output bit [7:0] second, output bit [5:0] pair);
        case (m)
            sst_pkg::M_MINUS:
            begin
                single = sst_pkg::K_MINUS; second = ">"; pair = sst_pkg::K_ARROW;
            end
            sst_pkg::M_BAR:
            begin
                single = sst_pkg::K_ERROR; second = ">"; pair = sst_pkg::K_PIPE;
            end
            sst_pkg::M_EQUAL:
            begin
                single = sst_pkg::K_ASSIGN; second = "="; pair = sst_pkg::K_EQEQ;
            end
            sst_pkg::M_BANG:
            begin
                single = sst_pkg::K_ERROR; second = "="; pair = sst_pkg::K_NE;
            end
            sst_pkg::M_LESS:
            begin
                single = sst_pkg::K_LT; second = "="; pair = sst_pkg::K_LE;
            end
            default:
            begin
                single = sst_pkg::K_GT; second = "="; pair = sst_pkg::K_GE;
            end
        endcase
    endfunction

    function automatic void open_token(sst_pkg::mode_t m, bit [31:0] pos, bit [15:0] len);
        mode = m;
        tok_start = pos;
        tok_len = len;
        tok_line = line_no;
    endfunction

    function automatic void start_char(bit [7:0] c, bit [31:0] pos);
        bit [5:0] k;
        mode = sst_pkg::M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0d) return;
        if (c == "#") begin mode = sst_pkg::M_COMMENT; return; end
        if (c == CH_LF) begin
            push(sst_pkg::K_NEWLINE, pos, 1, line_no, 0, 0);
            line_no++;
            return;
        end
        if (digit_char(c)) begin
            open_token(sst_pkg::M_NUMBER, pos, 1);
            whole = 64'(c - "0");
            return;
        end
        if (name_char(c)) begin
            open_token(sst_pkg::M_NAME, pos, 1);
            name_buf = string'(c);
            return;
        end
        case (c)
            "\"": begin open_token(sst_pkg::M_TEXT, pos + 1, 0); esc = 0; return; end
            "-": begin open_token(sst_pkg::M_MINUS, pos, 1); return; end
            "|": begin open_token(sst_pkg::M_BAR, pos, 1); return; end
            "=": begin open_token(sst_pkg::M_EQUAL, pos, 1); return; end
            "!": begin open_token(sst_pkg::M_BANG, pos, 1); return; end
            "<": begin open_token(sst_pkg::M_LESS, pos, 1); return; end
            ">": begin open_token(sst_pkg::M_GREATER, pos, 1); return; end
            default: ;
        endcase
        case (c)
            "+": k = sst_pkg::K_PLUS;
            "*": k = sst_pkg::K_STAR;
            "/": k = sst_pkg::K_SLASH;
            "%": k = sst_pkg::K_PCT;
            "^": k = sst_pkg::K_CARET;
            "(": k = sst_pkg::K_LPAR;
            ")": k = sst_pkg::K_RPAR;
            "[": k = sst_pkg::K_LBRK;
            "]": k = sst_pkg::K_RBRK;
            "{": k = sst_pkg::K_LBRC;
            "}": k = sst_pkg::K_RBRC;
            ",": k = sst_pkg::K_COMMA;
            ":": k = sst_pkg::K_COLON;
            ".": k = sst_pkg::K_DOT;
            default: k = sst_pkg::K_ERROR;
        endcase
        push(k, pos, 1, line_no, 0, 0);
    endfunction

    function automatic void flush_token(bit [31:0] pos);
        bit [5:0]  single, pair;
        bit [7:0]  second;
        bit [5:0]  k;
        bit [63:0] scale, frac;
        case (mode)
            sst_pkg::M_NUMBER: push(sst_pkg::K_INT, tok_start, tok_len, tok_line, whole, 0);
            sst_pkg::M_NUMDOT:
            begin
                push(sst_pkg::K_INT, tok_start, tok_len, tok_line, whole, 0);
                push(sst_pkg::K_DOT, pos - 1, 1, tok_line, 0, 0);
            end
            sst_pkg::M_FRAC:
            begin
                scale = 1;
                for (int i = 0; i < frac_digits; i++) scale = scale * 10;
                frac = (64'(frac_num) << FRAC) / scale;
                push(sst_pkg::K_REAL, tok_start, tok_len, tok_line, 0,
                     (whole << FRAC) + frac);
            end
            sst_pkg::M_NAME:
            begin
                k = sst_pkg::K_NAME;
                if (tok_len <= 7)
                    foreach (kw_words[i])
                        if (k == sst_pkg::K_NAME && name_buf == kw_words[i])
                            k = 6'(kw_kinds[i]);
                push(k, tok_start, tok_len, tok_line, 0, 0);
            end
            sst_pkg::M_TEXT: push(sst_pkg::K_TEXT, tok_start, tok_len, tok_line, 0, 0);
            sst_pkg::M_MINUS, sst_pkg::M_BAR, sst_pkg::M_EQUAL, sst_pkg::M_BANG,
            sst_pkg::M_LESS, sst_pkg::M_GREATER:
            begin
                op_kinds(mode, single, second, pair);
                push(single, tok_start, 1, tok_line, 0, 0);
            end
            default: ;
        endcase
        mode = sst_pkg::M_IDLE;
    endfunction

    function automatic void take_char(bit [7:0] c, bit [31:0] pos);
        bit [5:0] single, pair;
        bit [7:0] second;
        case (mode)
            sst_pkg::M_COMMENT:
            begin
                if (c == CH_LF) start_char(c, pos);
                return;
            end
            sst_pkg::M_NUMBER:
            begin
                if (digit_char(c)) begin
                    whole = whole * 10 + 64'(c - "0");
                    tok_len = len_plus(tok_len, 1);
                    return;
                end
                if (c == ".") begin mode = sst_pkg::M_NUMDOT; return; end
            end
            sst_pkg::M_NUMDOT:
                if (digit_char(c)) begin
                    mode = sst_pkg::M_FRAC;
                    tok_len = len_plus(tok_len, 2);
                    frac_num = 30'(c - "0");
                    frac_digits = 1;
                    return;
                end
            sst_pkg::M_FRAC:
                if (digit_char(c) && frac_digits < MAX_DIGITS) begin
                    frac_num = frac_num * 10 + 30'(c - "0");
                    frac_digits++;
                    tok_len = len_plus(tok_len, 1);
                    return;
                end
            sst_pkg::M_NAME:
                if (name_char(c) || digit_char(c)) begin
                    if (tok_len < 7) name_buf = {name_buf, string'(c)};
                    tok_len = len_plus(tok_len, 1);
                    return;
                end
            sst_pkg::M_TEXT:
            begin
                if (esc) esc = 0;
                else if (c == "\"") begin
                    push(sst_pkg::K_TEXT, tok_start, tok_len, tok_line, 0, 0);
                    mode = sst_pkg::M_IDLE;
                    return;
                end
                else if (c == "\\") esc = 1;
                if (c == CH_LF) line_no++;
                tok_len = len_plus(tok_len, 1);
                return;
            end
            sst_pkg::M_MINUS, sst_pkg::M_BAR, sst_pkg::M_EQUAL, sst_pkg::M_BANG,
            sst_pkg::M_LESS, sst_pkg::M_GREATER:
            begin
                op_kinds(mode, single, second, pair);
                if (c == second) begin
                    push(pair, tok_start, 2, tok_line, 0, 0);
                    mode = sst_pkg::M_IDLE;
                    return;
                end
            end
            default:
            begin
                start_char(c, pos);
                return;
            end
        endcase
        flush_token(pos);
        start_char(c, pos);
    endfunction

    function automatic void predict_tokens(bit k, bit [7:0] c);
        int        before_n;
        bit [31:0] pos;
        before_n = token_fifo.size();
        pos = offset;
        if (k || c == 0) begin
            flush_token(pos);
            push(sst_pkg::K_EOF, pos, 0, line_no, 0, 0);
            clear_scanner();
        end
        else begin
            take_char(c, pos);
            offset = pos + 1;
        end
        if (token_fifo.size() > before_n) token_fifo[token_fifo.size() - 1].last = 1;
    endfunction

    function automatic void check_field(string field, bit [63:0] exp_v, bit [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
            fails++;
        end
    endfunction

    initial
    begin
        fails = 0;
        bytes_seen = 0;
        tokens_seen = 0;
        clear_scanner();
    end

    assign pending = token_fifo.size();

    // Sample transfers at the edge; the byte is predicted before any token is matched.
    always @(posedge clk)
    begin
        expected_token_t e;
        if (rst_n) begin
            if (src_mon.valid && src_mon.ready) begin
                predict_tokens(src_mon.kind, src_mon.byte_value);
                bytes_seen++;
            end
            if (tok_mon.valid && tok_mon.ready) begin
                tokens_seen++;
                if (token_fifo.size() == 0) begin
                    $error("token kind %0d at offset %0d arrived with none expected",
                           tok_mon.token_kind, tok_mon.token_start);
                    fails++;
                end
                else begin
                    e = token_fifo.pop_front();
                    check_field("token_kind", e.tok.kind, tok_mon.token_kind);
                    check_field("token_start", e.tok.start, tok_mon.token_start);
                    check_field("token_length", e.tok.length, tok_mon.token_length);
                    check_field("token_line", e.tok.line, tok_mon.token_line);
                    check_field("integer_value", e.tok.ival, tok_mon.integer_value);
                    check_field("real_value", e.tok.rval, tok_mon.real_value);
                    check_field("last_of_run", e.last, tok_mon.last_of_run);
                end
            end
        end
    end

endmodule

// ===== tb/script_source_tokenizer_tb.sv =====
// Testbench top: clock, reset, byte stimulus, token back-pressure and verdict.
`timescale 1ns / 1ps
module script_source_tokenizer_tb;

    // Generous ceiling for a fully stalled run with a division on every byte.
    localparam int CYCLE_LIMIT = 250000;
    // Enough settling for a fraction division plus a full token run.
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_ITEMS = 240;

    logic clk = 0;
    logic rst_n = 0;
    int   src_idle = 0;
    int   rx_idle = 0;
    int   cycles = 0;
    int   fails, pending, bytes_seen, tokens_seen;
    int   sent;

    string kw_pick[29] = '{"let", "say", "ask", "if", "then", "else", "end", "while",
        "repeat", "until", "for", "each", "in", "fun", "return", "break", "skip",
        "match", "when", "and", "or", "not", "is", "true", "yes", "false", "no",
        "nothing", "to"};
    string op_pick[30] = '{"+", "-", "*", "/", "%", "^", "==", "!=", "<", "<=", ">",
        ">=", "=", "(", ")", "[", "]", "{", "}", ",", ":", ".", "->", "|>", "|",
        "!", "-x", "=x", "<x", ">x"};

    sst_byte_if  src ();
    sst_token_if tok ();

    script_source_tokenizer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src),
        .tok   (tok)
    );

    script_source_tokenizer_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_mon     (src),
        .tok_mon     (tok),
        .fails       (fails),
        .pending     (pending),
        .bytes_seen  (bytes_seen),
        .tokens_seen (tokens_seen)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial
    begin
        src.valid = 0;
        src.kind = 0;
        src.byte_value = 0;
    end

    // Receiver back-pressure: redraw ready every cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) tok.ready <= 1'b0;
        else tok.ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one byte and hold it until the transfer; drop valid only on an idle gap.
    task automatic send_byte(bit k, bit [7:0] b);
        if ($urandom_range(99) < src_idle) begin
            src.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle) @(posedge clk);
        end
        src.valid <= 1'b1;
        src.kind <= k;
        src.byte_value <= b;
        @(posedge clk);
        while (!src.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i]);
    endtask

    task automatic send_digits(int n);
        repeat (n) send_byte(1'b0, 8'(8'h30 + $urandom_range(9)));
    endtask

    // One random fragment: mostly well-formed tokens, with some noise and broken input.
    task automatic send_fragment();
        int    pick, n;
        bit [7:0] c;
        pick = $urandom_range(99);
        if (pick < 14) send_digits($urandom_range(1, 21));
        else if (pick < 26) begin
            send_digits($urandom_range(1, 4));
            send_byte(1'b0, ".");
            send_digits($urandom_range(1, 11));
        end
        else if (pick < 30) begin
            send_digits($urandom_range(1, 3));
            send_text(".a");
        end
        else if (pick < 40) send_text(kw_pick[$urandom_range(28)]);
        else if (pick < 50) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                c = (i > 0 && $urandom_range(3) == 0) ? 8'(8'h30 + $urandom_range(9))
                    : 8'(8'h61 + $urandom_range(25));
                if ($urandom_range(7) == 0) c = "_";
                if ($urandom_range(5) == 0 && c >= "a") c = c - 8'h20;
                send_byte(1'b0, c);
            end
        end
        else if (pick < 58) begin
            send_byte(1'b0, "\"");
            n = $urandom_range(0, 8);
            repeat (n) begin
                case ($urandom_range(5))
                    0: send_text("\\\"");
                    1: send_byte(1'b0, 8'h0a);
                    default: send_byte(1'b0, 8'($urandom_range(32, 126)));
                endcase
            end
            if ($urandom_range(5) != 0) send_byte(1'b0, "\"");
        end
        else if (pick < 70) send_text(op_pick[$urandom_range(29)]);
        else if (pick < 74) send_text("# note ok\n");
        else if (pick < 80) send_byte(1'b0, 8'h0a);
        else if (pick < 86) send_byte(1'b0, " ");
        else if (pick < 92) send_byte(1'b0, 8'($urandom_range(1, 255)));
        else if (pick < 97) send_byte(1'b1, 8'($urandom_range(255)));
        else send_byte(1'b0, 8'h00);
        // Separate most fragments so that they end cleanly.
        if ($urandom_range(2) != 0) send_byte(1'b0, " ");
    endtask

    initial
    begin
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operator class and the named corner cases.
        src_idle = 20;
        rx_idle = 30;
        send_text("18446744073709551617 ");
        send_text("3.1415926535 12.x ");
        send_text("let nothing nothingx if ");
        send_text("-> |> | ! != == <= >= = < > - ");
        send_text("+*/%^()[]{},:.~\n");
        send_text("\"a\\\"b\nc\" # skip\n");
        send_text("\"tail\\");
        send_byte(1'b1, 8'hff);
        send_text("x1");
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'h80);
        send_byte(1'b1, 8'h00);

        // Random: receiver-heavy idling, then sender-heavy, then none.
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 35 : (ph == 1) ? 82 : 0;
            rx_idle = (ph == 0) ? 82 : (ph == 1) ? 35 : 0;
            n_loop();
        end

        // Flush whatever the last fragment left pending.
        send_byte(1'b1, 8'h00);

        @(posedge clk);
        src.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d byte transfers and %0d token transfers", bytes_seen,
                 tokens_seen);
        $display("with numbers, reals, names, keywords, text, operators and end of input");
        if (fails == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    task automatic n_loop();
        int goal;
        goal = sent + RANDOM_ITEMS / 3;
        while (sent < goal) send_fragment();
    endtask

endmodule
